// ===== rtl/rsss_pkg.sv =====
// ----------------------------------------------------------------------------
// rsss_pkg
// Types and constants shared by the reciprocating stepper sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rsss_pkg;

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_CONT   = 2'd2,
    MODE_MANUAL = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    PH_START      = 5'b00001,
    PH_FWD        = 5'b00010,
    PH_PAUSE_FWD  = 5'b00100,
    PH_BACK       = 5'b01000,
    PH_PAUSE_BACK = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    MV_NONE = 2'd0,
    MV_ABS  = 2'd1,
    MV_REL  = 2'd2,
    MV_RUN  = 2'd3
  } move_e;

  // command codes
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_STOP      = 4'd1;
  localparam logic [3:0] CMD_SINGLE    = 4'd2;
  localparam logic [3:0] CMD_CONT      = 4'd3;
  localparam logic [3:0] CMD_TURN      = 4'd4;
  localparam logic [3:0] CMD_SET_REAR  = 4'd5;
  localparam logic [3:0] CMD_SET_FRONT = 4'd6;
  localparam logic [3:0] CMD_HALF_MAX  = 4'd7;
  localparam logic [3:0] CMD_FULL_MAX  = 4'd8;
  localparam logic [3:0] CMD_UP        = 4'd9;
  localparam logic [3:0] CMD_DOWN      = 4'd10;

  // turn type argument
  localparam logic [15:0] TURN_HALF = 16'd0;
  localparam logic [15:0] TURN_FULL = 16'd1;

  // register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_STEPS_PER_REV = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PAUSE_HALF_MS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PAUSE_FULL_MS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RETURN_SPEED  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RETURN_RAMP   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_JOG_SPEED     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_JOG_RAMP      = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_JOG_STEPS     = 3'd7;

  // reset values
  localparam logic [15:0] RST_STEPS_PER_REV = 16'd200;
  localparam logic [15:0] RST_PAUSE_HALF_MS = 16'd1000;
  localparam logic [15:0] RST_PAUSE_FULL_MS = 16'd300;
  localparam logic [15:0] RST_RETURN_SPEED  = 16'd90;
  localparam logic [7:0]  RST_RETURN_RAMP   = 8'd10;
  localparam logic [15:0] RST_JOG_SPEED     = 16'd30;
  localparam logic [7:0]  RST_JOG_RAMP      = 8'd3;
  localparam logic [14:0] RST_JOG_STEPS     = 15'd15;
  localparam logic [15:0] RST_SINGLE_SPEED  = 16'd100;
  localparam logic [15:0] RST_CONT_SPEED    = 16'd200;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 64;

  typedef struct packed {
    logic [15:0] steps_per_rev;
    logic [15:0] pause_half_ms;
    logic [15:0] pause_full_ms;
    logic [15:0] return_speed;
    logic [7:0]  return_ramp;
    logic [15:0] jog_speed;
    logic [7:0]  jog_ramp;
    logic [14:0] jog_steps;
  } cfg_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [15:0]        value;
    logic               motor_running;
    logic signed [31:0] motor_position;
    logic [31:0]        now_ms;
  } poll_t;

  typedef struct packed {
    logic               disable_motor;
    logic               set_zero;
    logic               load_ramp;
    logic [7:0]         ramp_len;
    logic               load_speed;
    logic [15:0]        speed;
    move_e              move_kind;
    logic signed [31:0] move_target;
    logic               turn_finished;
    mode_e              active_mode;
  } order_t;

endpackage

`default_nettype wire

// ===== rtl/rsss_cfg.sv =====
// ----------------------------------------------------------------------------
// rsss_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsss_cfg
  import rsss_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [CfgIdxW-1:0]  idx_i,
  input  wire logic [CfgDataW-1:0] data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        REG_STEPS_PER_REV: cfg_d.steps_per_rev = data_i;
        REG_PAUSE_HALF_MS: cfg_d.pause_half_ms = data_i;
        REG_PAUSE_FULL_MS: cfg_d.pause_full_ms = data_i;
        REG_RETURN_SPEED:  cfg_d.return_speed  = data_i;
        REG_RETURN_RAMP:   cfg_d.return_ramp   = data_i[7:0];
        REG_JOG_SPEED:     cfg_d.jog_speed     = data_i;
        REG_JOG_RAMP:      cfg_d.jog_ramp      = data_i[7:0];
        REG_JOG_STEPS:     cfg_d.jog_steps     = data_i[14:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_rev <= RST_STEPS_PER_REV;
      cfg_q.pause_half_ms <= RST_PAUSE_HALF_MS;
      cfg_q.pause_full_ms <= RST_PAUSE_FULL_MS;
      cfg_q.return_speed  <= RST_RETURN_SPEED;
      cfg_q.return_ramp   <= RST_RETURN_RAMP;
      cfg_q.jog_speed     <= RST_JOG_SPEED;
      cfg_q.jog_ramp      <= RST_JOG_RAMP;
      cfg_q.jog_steps     <= RST_JOG_STEPS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/rsss_core.sv =====
// ----------------------------------------------------------------------------
// rsss_core
// Sequencer state and the per-poll decision logic: command decode, mode
// handover and the motion phase machine of each mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rsss_core
  import rsss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire cfg_t  cfg_i,
  input  wire poll_t poll_i,
  output order_t     order_o
);

  mode_e       cur_q, cur_d, pend_q, pend_d;
  phase_e      ph_q, ph_d;
  logic        done_q, done_d;
  logic        fk_q, fk_d, rk_q, rk_d;
  logic [31:0] fo_q, fo_d;
  logic        full_q, full_d;
  logic [15:0] srs_q, srs_d, cs_q, cs_d;
  logic        jb_q, jb_d;
  logic [31:0] fps_q, fps_d, bps_q, bps_d;

  logic [31:0] pos;
  logic [31:0] el_front, el_back;
  logic [31:0] pause_sel;
  order_t      o;

  assign el_front  = poll_i.now_ms - fps_q;
  assign el_back   = poll_i.now_ms - bps_q;

  always_comb begin
    cur_d  = cur_q;
    pend_d = pend_q;
    ph_d   = ph_q;
    done_d = done_q;
    fk_d   = fk_q;
    rk_d   = rk_q;
    fo_d   = fo_q;
    full_d = full_q;
    srs_d  = srs_q;
    cs_d   = cs_q;
    jb_d   = jb_q;
    fps_d  = fps_q;
    bps_d  = bps_q;
    pos    = poll_i.motor_position;
    o      = '0;

    unique case (poll_i.cmd)
      CMD_STOP: pend_d = MODE_STOP;
      CMD_SINGLE: begin
        if (fk_q && rk_q) begin
          srs_d  = poll_i.value;
          pend_d = MODE_SINGLE;
        end
      end
      CMD_CONT: begin
        if (fk_q && rk_q) begin
          cs_d   = poll_i.value;
          pend_d = MODE_CONT;
        end
      end
      CMD_TURN: begin
        if (poll_i.value == TURN_FULL) begin
          full_d = 1'b1;
        end else if (poll_i.value == TURN_HALF) begin
          full_d = 1'b0;
        end
      end
      CMD_SET_REAR: begin
        if (fk_q) begin
          fo_d = fo_q - poll_i.motor_position;
        end
        o.set_zero = 1'b1;
        pos        = '0;
        rk_d       = 1'b1;
      end
      CMD_SET_FRONT: begin
        fo_d = poll_i.motor_position;
        fk_d = 1'b1;
      end
      CMD_UP, CMD_DOWN: begin
        if (cur_q == MODE_STOP) begin
          pend_d = MODE_MANUAL;
          jb_d   = (poll_i.cmd == CMD_DOWN);
        end
      end
      default: ;
    endcase

    if (pend_d != cur_d && done_d) begin
      cur_d = pend_d;
    end

    pause_sel = {16'd0, (full_d ? cfg_i.pause_full_ms : cfg_i.pause_half_ms)};

    unique case (cur_d)
      MODE_SINGLE: begin
        unique case (ph_q)
          PH_START: begin
            done_d        = 1'b0;
            o.load_speed  = 1'b1;
            o.speed       = srs_d;
            o.move_kind   = MV_ABS;
            o.move_target = full_d ? {16'd0, cfg_i.steps_per_rev} : fo_d;
            ph_d          = PH_FWD;
          end
          PH_FWD: begin
            if (!poll_i.motor_running) begin
              ph_d  = PH_PAUSE_FWD;
              fps_d = poll_i.now_ms;
            end
          end
          PH_PAUSE_FWD: begin
            if (el_front > pause_sel) begin
              o.load_ramp  = 1'b1;
              o.ramp_len   = cfg_i.return_ramp;
              o.load_speed = 1'b1;
              o.speed      = cfg_i.return_speed;
              if (!full_d) begin
                o.move_kind   = MV_ABS;
                o.move_target = '0;
                ph_d          = PH_BACK;
              end else begin
                o.set_zero  = 1'b1;
                ph_d        = PH_START;
                pend_d      = MODE_STOP;
                done_d      = 1'b1;
                o.load_ramp = 1'b1;
                o.ramp_len  = '0;
              end
            end
          end
          PH_BACK: begin
            if (!poll_i.motor_running) begin
              ph_d        = PH_START;
              pend_d      = MODE_STOP;
              done_d      = 1'b1;
              o.load_ramp = 1'b1;
              o.ramp_len  = '0;
            end
          end
          default: ;
        endcase
      end
      MODE_CONT: begin
        unique case (ph_q)
          PH_START: begin
            done_d       = 1'b0;
            o.load_speed = 1'b1;
            o.speed      = cs_d;
            if (!full_d) begin
              o.move_kind   = MV_ABS;
              o.move_target = fo_d;
            end
            ph_d = PH_FWD;
          end
          PH_FWD: begin
            if (!full_d) begin
              if (!poll_i.motor_running) begin
                ph_d  = PH_PAUSE_FWD;
                fps_d = poll_i.now_ms;
              end
            end else begin
              done_d      = 1'b0;
              o.move_kind = MV_RUN;
              if ($signed(pos) >= $signed({16'd0, cfg_i.steps_per_rev})) begin
                o.set_zero = 1'b1;
                done_d     = 1'b1;
              end
              if (done_d && pend_d == MODE_STOP) begin
                ph_d  = PH_START;
                cur_d = MODE_STOP;
              end
            end
          end
          PH_PAUSE_FWD: begin
            if (el_front >= {16'd0, cfg_i.pause_half_ms}) begin
              o.load_ramp   = 1'b1;
              o.ramp_len    = cfg_i.return_ramp;
              o.load_speed  = 1'b1;
              o.speed       = cfg_i.return_speed;
              o.move_kind   = MV_ABS;
              o.move_target = '0;
              ph_d          = PH_BACK;
            end
          end
          PH_BACK: begin
            if (!poll_i.motor_running) begin
              ph_d  = PH_PAUSE_BACK;
              bps_d = poll_i.now_ms;
            end
          end
          PH_PAUSE_BACK: begin
            if (el_back >= {16'd0, cfg_i.pause_half_ms}) begin
              ph_d        = PH_START;
              done_d      = 1'b1;
              o.load_ramp = 1'b1;
              o.ramp_len  = '0;
            end
          end
          default: ;
        endcase
      end
      MODE_MANUAL: begin
        unique case (ph_q)
          PH_START: begin
            done_d       = 1'b0;
            o.load_ramp  = 1'b1;
            o.ramp_len   = cfg_i.jog_ramp;
            o.load_speed = 1'b1;
            o.speed      = cfg_i.jog_speed;
            o.move_kind  = MV_REL;
            if (!jb_d) begin
              o.move_target = {17'd0, cfg_i.jog_steps};
              ph_d          = PH_FWD;
            end else begin
              o.move_target = 32'd0 - {17'd0, cfg_i.jog_steps};
              ph_d          = PH_BACK;
            end
          end
          PH_FWD, PH_BACK: begin
            if (!poll_i.motor_running) begin
              ph_d        = PH_START;
              pend_d      = MODE_STOP;
              done_d      = 1'b1;
              o.load_ramp = 1'b1;
              o.ramp_len  = '0;
            end
          end
          default: ;
        endcase
      end
      MODE_STOP: begin
        o.disable_motor = 1'b1;
        ph_d            = PH_START;
      end
    endcase

    o.turn_finished = done_d;
    o.active_mode   = cur_d;
  end

  assign order_o = o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= MODE_STOP;
      pend_q <= MODE_STOP;
      ph_q   <= PH_START;
      done_q <= 1'b1;
      fk_q   <= 1'b0;
      rk_q   <= 1'b0;
      fo_q   <= '0;
      full_q <= 1'b0;
      srs_q  <= RST_SINGLE_SPEED;
      cs_q   <= RST_CONT_SPEED;
      jb_q   <= 1'b0;
      fps_q  <= '0;
      bps_q  <= '0;
    end else if (step_i) begin
      cur_q  <= cur_d;
      pend_q <= pend_d;
      ph_q   <= ph_d;
      done_q <= done_d;
      fk_q   <= fk_d;
      rk_q   <= rk_d;
      fo_q   <= fo_d;
      full_q <= full_d;
      srs_q  <= srs_d;
      cs_q   <= cs_d;
      jb_q   <= jb_d;
      fps_q  <= fps_d;
      bps_q  <= bps_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/reciprocating_stepper_sequencer_unit.sv =====
// Datapath: an accepted poll is held in the input register, and its order is then
// captured in the result register, which drives the output.
// Throughput: one poll per cycle, limited only by downstream tready.
// Reset: asynchronous, active low; clears the valid flags of both stages, sets the sequencer
// to stop mode with no ends defined and loads the register defaults.
// ----------------------------------------------------------------------------
// reciprocating_stepper_sequencer_unit
// Motion sequencer for a reciprocating stepper axis, one poll per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module reciprocating_stepper_sequencer_unit
  import rsss_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // polls
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // value[15:0], motor_running[16], motor_position[48:17], now_ms[80:49], zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // cmd[3:0]
  input  wire logic [3:0]          s_axis_tuser,
  // motor orders
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // disable_motor[0], set_zero[1], load_ramp[2], ramp_len[10:3], load_speed[11],
  // speed[27:12], move_target[59:28], turn_finished[60], active_mode[62:61], zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  // move_kind[1:0]
  output logic [1:0]               m_axis_tuser
);

  cfg_t   cfg;
  poll_t  poll_in, poll_q;
  order_t order, order_q;
  logic   in_valid_q, out_valid_q;
  logic   advance, step, in_xfer;

  assign poll_in.cmd            = s_axis_tuser;
  assign poll_in.value          = s_axis_tdata[15:0];
  assign poll_in.motor_running  = s_axis_tdata[16];
  assign poll_in.motor_position = s_axis_tdata[48:17];
  assign poll_in.now_ms         = s_axis_tdata[80:49];

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign step          = in_valid_q && advance;

  rsss_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  rsss_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .cfg_i   (cfg),
    .poll_i  (poll_q),
    .order_o (order)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      poll_q <= poll_in;
    end
    if (step) begin
      order_q <= order;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = order_q.move_kind;
  assign m_axis_tdata  = {1'b0,
                          order_q.active_mode,
                          order_q.turn_finished,
                          order_q.move_target,
                          order_q.speed,
                          order_q.load_speed,
                          order_q.ramp_len,
                          order_q.load_ramp,
                          order_q.set_zero,
                          order_q.disable_motor};

  a_target_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (order_q.move_kind == MV_NONE || order_q.move_kind == MV_RUN)
      |-> order_q.move_target == '0)
    else $error("move target set without a targeted move");

  a_loads_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (order_q.load_ramp || order_q.ramp_len == '0) &&
                    (order_q.load_speed || order_q.speed == '0))
    else $error("ramp or speed value without its load flag");

  a_disable_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && order_q.disable_motor
      |-> order_q.active_mode == MODE_STOP && order_q.move_kind == MV_NONE)
    else $error("driver disabled outside stop mode or with a move");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("poll held in input stage while result stage was empty");

endmodule

`default_nettype wire
